### rtl/core/ugs_pkg.sv
// Shared types and constants for the undirected graph store.
package ugs_pkg;

  // Graph size and derived widths.
  localparam int MAX_VERTICES = 16;
  localparam int VW           = $clog2(MAX_VERTICES);
  localparam int VCW          = $clog2(MAX_VERTICES + 1);
  localparam int EDGE_W       = 7;

  localparam logic [EDGE_W-1:0] EDGE_LIMIT = 7'd127;
  localparam logic [VCW-1:0]    COUNT_RESET = VCW'(16);

  typedef logic [MAX_VERTICES-1:0] row_t;
  typedef logic [VW-1:0]           vertex_t;
  typedef logic [VCW-1:0]          count_t;

  // Command codes carried in the input tuser.
  typedef enum logic [1:0] {
    CMD_INSERT  = 2'd0,
    CMD_QUERY   = 2'd1,
    CMD_PATH    = 2'd2,
    CMD_CONNECT = 2'd3
  } cmd_t;

  // One access request to the adjacency store.
  typedef struct packed {
    logic    rd_en;
    vertex_t rd_addr;
    logic    wr_en;
    vertex_t wr_addr;
    row_t    wr_data;
  } mem_req_t;

endpackage

### rtl/core/ugs_adj_store.sv
// Adjacency row memory with per-row valid bits so that reset empties the graph at once.
module ugs_adj_store (
  input  logic              clk,
  input  logic              rst,
  input  ugs_pkg::mem_req_t req,
  output ugs_pkg::row_t     rd_row
);
  import ugs_pkg::*;

  row_t                    mem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] row_valid;
  row_t                    rd_q;
  logic                    rd_ok;

  // Row storage: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_q <= mem[req.rd_addr];
    end
  end

  // Valid bits: a row never written since reset reads as empty.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      rd_ok     <= 1'b0;
    end else begin
      if (req.wr_en) begin
        row_valid[req.wr_addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_ok <= row_valid[req.rd_addr];
      end
    end
  end

  assign rd_row = rd_ok ? rd_q : '0;

endmodule

### rtl/core/undirected_graph_store_with_checks_core.sv
// Top level of the undirected graph store: command sequencer, path tracker and connectivity walk.
//
// Input beats carry a command in s_axis_tuser and two vertices in s_axis_tdata;
// s_axis_tlast marks the final vertex of a path. One item is worked at a time:
// s_axis_tready is high only while the sequencer is idle.
// Output beats carry answer and the edge total in m_axis_tdata and the range
// status in m_axis_tuser. Path items not marked last give no output beat.
// Query and insert read the row of vertex_a and then check it; an insert that adds the edge
// writes that row, then the row of vertex_b. Insert or query with an out-of-range vertex
// skips the check. A path item reads the row of the previous vertex, then checks it.
// Connect sweeps the rows of the vertices in use through the single memory
// read port, one row per cycle, and repeats while the reach set still grows,
// at most 16 sweeps.
// The result sits in an output register; a stalled receiver holds it there
// and a following item may be accepted meanwhile, but its own result then
// waits until the register is freed.
// vertex_count is written through cfg_wr_en / cfg_wr_data; the user must do so only while idle,
// as the block does not enforce it. Reset (rst, synchronous) empties the graph, clears the edge
// count and path state and sets vertex_count to 16.
module undirected_graph_store_with_checks_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [3:0] vertex_a, [7:4] vertex_b
  input  logic       s_axis_tlast,   // last_in_path
  input  logic [1:0] s_axis_tuser,   // [1:0] cmd
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [0] answer, [7:1] edge_total
  output logic       m_axis_tuser,   // [0] status
  input  logic       cfg_wr_en,
  input  logic [4:0] cfg_wr_data     // vertex_count
);
  import ugs_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_CHECK, S_WRITE_B, S_CONN, S_DONE
  } state_t;

  state_t              state;
  cmd_t                cmd;
  vertex_t             vtx_a;
  vertex_t             vtx_b;
  logic                last_item;
  count_t              vertex_count;
  count_t              n_live;
  row_t                live_mask;
  logic [EDGE_W-1:0]   edge_counter;
  row_t                path_seen;
  vertex_t             path_previous;
  logic                path_started;
  logic                path_valid;
  logic                path_range_error;
  row_t                reached_set;
  count_t              walk_rd;
  logic                walk_vld;
  vertex_t             walk_pv;
  logic                walk_chg;
  row_t                reach_next;
  logic                res_answer;
  logic                res_status;
  mem_req_t            mem_req;
  row_t                rd_row;
  logic                a_in;
  logic                b_in;
  logic                add_edge;
  logic                out_free;
  logic                pv_next;
  logic                err_next;

  ugs_adj_store u_store (
    .clk    (clk),
    .rst    (rst),
    .req    (mem_req),
    .rd_row (rd_row)
  );

  // Effective vertex count, clamped to one through MAX_VERTICES.
  always_comb begin
    if (vertex_count == '0) begin
      n_live = count_t'(1);
    end else if (vertex_count > count_t'(MAX_VERTICES)) begin
      n_live = count_t'(MAX_VERTICES);
    end else begin
      n_live = vertex_count;
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_VERTICES; i++) begin
      live_mask[i] = count_t'(i) < n_live;
    end
  end

  // Range checks and the insert decision on the row just read.
  assign a_in     = {1'b0, vtx_a} < n_live;
  assign b_in     = {1'b0, vtx_b} < n_live;
  assign add_edge = (vtx_a != vtx_b) && !rd_row[vtx_b];
  assign out_free = !m_axis_tvalid || m_axis_tready;

  // Path flags after the current vertex is applied.
  assign pv_next  = path_valid &&
                    !(a_in && path_started && (path_seen[vtx_a] || !rd_row[vtx_a]));
  assign err_next = path_range_error || !a_in;

  // Connect walk: fold in the row that just arrived if its vertex is reached.
  always_comb begin
    reach_next = reached_set;
    if (walk_vld && reached_set[walk_pv]) begin
      reach_next = reached_set | (rd_row & live_mask);
    end
  end

  // Memory requests for each step.
  always_comb begin
    mem_req = '0;
    unique case (state)
      S_READ: begin
        mem_req.rd_en   = 1'b1;
        mem_req.rd_addr = (cmd == CMD_PATH) ? path_previous : vtx_a;
      end
      S_CHECK: begin
        if (cmd == CMD_INSERT && add_edge) begin
          mem_req.wr_en   = 1'b1;
          mem_req.wr_addr = vtx_a;
          mem_req.wr_data = rd_row | (row_t'(1) << vtx_b);
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = vtx_b;
        end
      end
      S_WRITE_B: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = vtx_b;
        mem_req.wr_data = rd_row | (row_t'(1) << vtx_a);
      end
      S_CONN: begin
        mem_req.rd_en   = walk_rd < n_live;
        mem_req.rd_addr = walk_rd[VW-1:0];
      end
      default: begin
        mem_req = '0;
      end
    endcase
  end

  assign s_axis_tready = (state == S_IDLE);

  // Sequencer with its state registers and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      vertex_count     <= COUNT_RESET;
      edge_counter     <= '0;
      path_seen        <= '0;
      path_previous    <= '0;
      path_started     <= 1'b0;
      path_valid       <= 1'b1;
      path_range_error <= 1'b0;
      reached_set      <= '0;
      walk_rd          <= '0;
      walk_vld         <= 1'b0;
      walk_chg         <= 1'b0;
      m_axis_tvalid    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        vertex_count <= cfg_wr_data;
      end
      // A beat taken by the receiver leaves the register empty unless a new one is loaded.
      if (m_axis_tvalid && m_axis_tready && state != S_DONE) begin
        m_axis_tvalid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            cmd       <= cmd_t'(s_axis_tuser);
            vtx_a     <= s_axis_tdata[3:0];
            vtx_b     <= s_axis_tdata[7:4];
            last_item <= s_axis_tlast;
            state     <= S_READ;
          end
        end

        S_READ: begin
          if (cmd == CMD_CONNECT) begin
            reached_set <= row_t'(1);
            walk_rd     <= '0;
            walk_vld    <= 1'b0;
            walk_chg    <= 1'b0;
            state       <= S_CONN;
          end else if (cmd != CMD_PATH && !(a_in && b_in)) begin
            res_answer <= 1'b0;
            res_status <= 1'b1;
            state      <= S_DONE;
          end else begin
            state <= S_CHECK;
          end
        end

        S_CHECK: begin
          if (cmd == CMD_PATH) begin
            if (last_item) begin
              res_answer       <= pv_next && !err_next;
              res_status       <= err_next;
              path_seen        <= '0;
              path_previous    <= '0;
              path_started     <= 1'b0;
              path_valid       <= 1'b1;
              path_range_error <= 1'b0;
              state            <= S_DONE;
            end else begin
              path_valid       <= pv_next;
              path_range_error <= err_next;
              if (a_in) begin
                path_seen     <= path_seen | (row_t'(1) << vtx_a);
                path_previous <= vtx_a;
                path_started  <= 1'b1;
              end
              state <= S_IDLE;
            end
          end else if (cmd == CMD_INSERT && add_edge) begin
            state <= S_WRITE_B;
          end else begin
            res_answer <= (cmd == CMD_QUERY) && rd_row[vtx_b];
            res_status <= 1'b0;
            state      <= S_DONE;
          end
        end

        S_WRITE_B: begin
          if (edge_counter < EDGE_LIMIT) begin
            edge_counter <= edge_counter + EDGE_W'(1);
          end
          res_answer <= 1'b1;
          res_status <= 1'b0;
          state      <= S_DONE;
        end

        S_CONN: begin
          reached_set <= reach_next;
          if (reach_next != reached_set) begin
            walk_chg <= 1'b1;
          end
          if (walk_rd < n_live) begin
            walk_vld <= 1'b1;
            walk_pv  <= walk_rd[VW-1:0];
            walk_rd  <= walk_rd + count_t'(1);
          end else begin
            walk_vld <= 1'b0;
            // Sweep finished: repeat while it grew, otherwise report.
            if (!walk_vld) begin
              if (walk_chg) begin
                walk_rd  <= '0;
                walk_chg <= 1'b0;
              end else begin
                res_answer <= (reached_set == live_mask);
                res_status <= 1'b0;
                state      <= S_DONE;
              end
            end
          end
        end

        S_DONE: begin
          if (out_free) begin
            m_axis_tvalid     <= 1'b1;
            m_axis_tdata      <= {edge_counter, res_answer};
            m_axis_tuser      <= res_status;
            state             <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
